FILE: hdl/nss_pkg.sv
// nss_pkg: shared constants, types and helpers for the nfa subset step block
// depends on nothing; used by nss_closure, nfa_subset_step and nss_checker
package nss_pkg;

    localparam int NUM_STATES  = 8;
    localparam int NUM_SYMBOLS = 4;

    localparam int SET_W   = 8;
    localparam int MATRIX_W = 64;
    localparam int SYM_W   = 2;
    localparam int CNT_W   = 3;
    localparam int INDEX_W = 3;

    localparam logic [SET_W-1:0] STATE_MASK = SET_W'((9'd1 << NUM_STATES) - 9'd1);

    typedef enum logic
    {
        KIND_CLOSURE   = 1'b0,
        KIND_SUCCESSOR = 1'b1
    } kind_t;

    typedef enum logic [INDEX_W-1:0]
    {
        REG_EPS_MOVES    = 3'd0,
        REG_SYM0_MOVES   = 3'd1,
        REG_SYM1_MOVES   = 3'd2,
        REG_SYM2_MOVES   = 3'd3,
        REG_SYM3_MOVES   = 3'd4,
        REG_SYMBOL_COUNT = 3'd5
    } reg_index_t;

    // union of the matrix rows of every member state
    function automatic logic [SET_W-1:0] move_set(
        input logic [MATRIX_W-1:0] matrix,
        input logic [SET_W-1:0]    set
    );
        logic [SET_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < NUM_STATES; i++)
        begin
            if (set[i])
            begin
                acc = acc | (matrix[8*i +: 8] & STATE_MASK);
            end
        end
        return acc;
    endfunction

endpackage

FILE: hdl/nfa_subset_step.sv
// nfa_subset_step: top level, config registers, item register and result register
// depends on nss_pkg and nss_closure
//
// an accepted item waits in the item register, its results go out through the result register
// throughput, set by the single shared move-and-closure unit behind the item register:
// closure items 1 per cycle, successor items one symbol per cycle (1 to 4), if not stalled
// reset: rst_n asynchronous active low, clears valids, matrices to 0, symbol count to 1
module nfa_subset_step
    import nss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input items
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [SET_W-1:0]    state_set,
    // result items
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SET_W-1:0]    result_set,
    output logic [SYM_W-1:0]    symbol_index,
    output logic                last,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [MATRIX_W-1:0] cfg_data
);

    // configuration registers
    logic [MATRIX_W-1:0] eps_moves_reg;
    logic [MATRIX_W-1:0] sym_moves_reg [NUM_SYMBOLS];
    logic [CNT_W-1:0]    symbol_count_reg;

    // item register: the item being worked through, one symbol per cycle while results drain
    logic                a_valid_reg;
    logic                a_valid_next;
    kind_t               a_kind_reg;
    logic [SET_W-1:0]    a_set_reg;
    logic [SYM_W-1:0]    a_sym_reg;
    logic [SYM_W-1:0]    a_sym_next;

    // result register
    logic                o_valid_reg;
    logic [SET_W-1:0]    o_set_reg;
    logic [SYM_W-1:0]    o_sym_reg;
    logic                o_last_reg;

    logic [SYM_W-1:0]    last_sym;
    logic                a_last;
    logic                adv_a;
    logic                a_done;
    logic                in_acc;
    logic [SET_W-1:0]    closed_set;

    // config port never back-pressures
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_moves_reg    <= '0;
            symbol_count_reg <= CNT_W'(1);
            for (int k = 0; k < NUM_SYMBOLS; k++)
            begin
                sym_moves_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_EPS_MOVES:    eps_moves_reg    <= cfg_data;
                REG_SYM0_MOVES:   sym_moves_reg[0] <= cfg_data;
                REG_SYM1_MOVES:   if (NUM_SYMBOLS > 1) sym_moves_reg[1 % NUM_SYMBOLS] <= cfg_data;
                REG_SYM2_MOVES:   if (NUM_SYMBOLS > 2) sym_moves_reg[2 % NUM_SYMBOLS] <= cfg_data;
                REG_SYM3_MOVES:   if (NUM_SYMBOLS > 3) sym_moves_reg[3 % NUM_SYMBOLS] <= cfg_data;
                REG_SYMBOL_COUNT: symbol_count_reg <= cfg_data[CNT_W-1:0];
                default:          ;   // index beyond the list is dropped
            endcase
        end
    end

    // last symbol in use: zero counts as one, large counts saturate
    always_comb
    begin
        if (symbol_count_reg == '0)
        begin
            last_sym = '0;
        end
        else if (symbol_count_reg > CNT_W'(NUM_SYMBOLS))
        begin
            last_sym = SYM_W'(NUM_SYMBOLS - 1);
        end
        else
        begin
            last_sym = SYM_W'(symbol_count_reg - CNT_W'(1));
        end
    end

    // closure items finish in one pass, successor items at the last symbol
    assign a_last = (a_kind_reg == KIND_CLOSURE) || (a_sym_reg == last_sym);

    // item register hands a result over whenever the result register is free or draining
    assign adv_a  = a_valid_reg && (!o_valid_reg || !out_stall);
    assign a_done = adv_a && a_last;

    // take the next item in the same cycle the current one hands over its final result
    assign in_stall = a_valid_reg && !a_done;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_sym_next   = a_sym_reg;
        if (in_acc)
        begin
            a_valid_next = 1'b1;
            a_sym_next   = '0;
        end
        else if (a_done)
        begin
            a_valid_next = 1'b0;
        end
        else if (adv_a)
        begin
            a_sym_next = a_sym_reg + SYM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_sym_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            a_sym_reg   <= a_sym_next;
        end
    end

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_kind_reg <= kind_t'(kind);
            a_set_reg  <= state_set;
        end
    end

    // shared move and epsilon closure for the current symbol
    nss_closure u_closure
    (
        .kind       (a_kind_reg),
        .state_set  (a_set_reg),
        .sym_moves  (sym_moves_reg[a_sym_reg]),
        .eps_moves  (eps_moves_reg),
        .closed_set (closed_set)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (adv_a)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            o_set_reg  <= closed_set;
            o_sym_reg  <= (a_kind_reg == KIND_CLOSURE) ? '0 : a_sym_reg;
            o_last_reg <= a_last;
        end
    end

    assign out_valid    = o_valid_reg;
    assign result_set   = o_set_reg;
    assign symbol_index = o_sym_reg;
    assign last         = o_last_reg;

endmodule

FILE: hdl/nss_closure.sv
// nss_closure: one symbol move followed by the epsilon closure, all combinational
// depends on nss_pkg
module nss_closure
    import nss_pkg::*;
(
    input  kind_t                kind,
    input  logic [SET_W-1:0]     state_set,
    input  logic [MATRIX_W-1:0]  sym_moves,
    input  logic [MATRIX_W-1:0]  eps_moves,
    output logic [SET_W-1:0]     closed_set
);

    logic [SET_W-1:0] start_set;
    logic [SET_W-1:0] cur;

    always_comb
    begin
        if (kind == KIND_SUCCESSOR)
        begin
            start_set = move_set(sym_moves, state_set & STATE_MASK);
        end
        else
        begin
            start_set = state_set & STATE_MASK;
        end
    end

    // bounded fixpoint, one round per state
    always_comb
    begin
        cur = start_set;
        for (int r = 0; r < NUM_STATES; r++)
        begin
            cur = cur | move_set(eps_moves, cur);
        end
        closed_set = cur & STATE_MASK;
    end

endmodule

FILE: hdl/nss_checker.sv
// nss_checker: port-level assertions for nfa_subset_step, bound to the top level
// depends on nss_pkg and nfa_subset_step
module nss_checker
    import nss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [SET_W-1:0]    result_set,
    input  logic [SYM_W-1:0]    symbol_index,
    input  logic                last
);

    // no result shows while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // a result at the highest symbol index always carries last
    a_last_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> symbol_index != SYM_W'(NUM_SYMBOLS - 1))
        else $error("result at last symbol without last flag");

    // results never name states that do not exist
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_set & ~STATE_MASK) == '0)
        else $error("result names state beyond range");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_set)
            && $stable(symbol_index) && $stable(last))
        else $error("stalled result changed");

endmodule

bind nfa_subset_step nss_checker u_nss_checker (.*);

FILE: dv/nfa_subset_step_test.sv
`timescale 1ns / 100ps
// nfa_subset_step_test: self-checking bench for the nfa subset step block
// drives state sets and table writes, predicts closed sets in a scoreboard class
// depends on nss_pkg and the nfa_subset_step rtl

import nss_pkg::*;

typedef struct packed
{
    logic [SET_W-1:0] result_set;
    logic [SYM_W-1:0] symbol_index;
    logic             last;
} closed_result_t;

typedef logic [MATRIX_W-1:0] move_tables_t [5];

class closure_scoreboard;
    logic [MATRIX_W-1:0] eps_rows;
    logic [MATRIX_W-1:0] sym_rows [NUM_SYMBOLS];
    logic [CNT_W-1:0]    symbols_in_use;
    closed_result_t      awaited [$];
    int errors;
    int closure_sets;
    int successor_sets;
    int results_seen;

    function new();
        eps_rows = '0;
        foreach (sym_rows[k])
            sym_rows[k] = '0;
        symbols_in_use = CNT_W'(1);
        errors = 0;
        closure_sets = 0;
        successor_sets = 0;
        results_seen = 0;
    endfunction

    function void set_register(logic [INDEX_W-1:0] index, logic [MATRIX_W-1:0] data);
        case (index)
            REG_EPS_MOVES:    eps_rows = data;
            REG_SYM0_MOVES:   sym_rows[0] = data;
            REG_SYM1_MOVES:   sym_rows[1] = data;
            REG_SYM2_MOVES:   sym_rows[2] = data;
            REG_SYM3_MOVES:   sym_rows[3] = data;
            REG_SYMBOL_COUNT: symbols_in_use = data[CNT_W-1:0];
            default:          ;
        endcase
    endfunction

    // states reachable in one move, only rows and columns of real states count
    function logic [SET_W-1:0] targets_of(logic [MATRIX_W-1:0] rows, logic [SET_W-1:0] from);
        logic [SET_W-1:0] reach;
        reach = '0;
        for (int i = 0; i < NUM_STATES; i++)
            for (int j = 0; j < NUM_STATES; j++)
                if (from[i] && rows[8*i + j])
                    reach[j] = 1'b1;
        return reach;
    endfunction

    function logic [SET_W-1:0] closed(logic [SET_W-1:0] from);
        logic [SET_W-1:0] cur;
        cur = from & STATE_MASK;
        repeat (NUM_STATES)
            cur = cur | targets_of(eps_rows, cur);
        return cur;
    endfunction

    function void note_set(kind_t kind, logic [SET_W-1:0] state_set);
        closed_result_t r;
        logic [SET_W-1:0] from;
        int count;
        from = state_set & STATE_MASK;
        if (kind == KIND_CLOSURE)
        begin
            closure_sets++;
            r.result_set = closed(from);
            r.symbol_index = '0;
            r.last = 1'b1;
            awaited.insert(awaited.size(), r);
            return;
        end
        successor_sets++;
        count = symbols_in_use;
        if (count < 1)
            count = 1;
        if (count > NUM_SYMBOLS)
            count = NUM_SYMBOLS;
        for (int n = 0; n < count; n++)
        begin
            r.result_set = closed(targets_of(sym_rows[n], from));
            r.symbol_index = SYM_W'(n);
            r.last = (n == count - 1);
            awaited.insert(awaited.size(), r);
        end
    endfunction

    task report_mismatch(string what, logic [SET_W-1:0] got, logic [SET_W-1:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
        errors++;
    endtask

    task check_result(logic [SET_W-1:0] result_set, logic [SYM_W-1:0] symbol_index, logic last);
        closed_result_t want;
        results_seen++;
        if (awaited.size() == 0)
        begin
            report_mismatch("unexpected result, set", result_set, '0);
            return;
        end
        want = awaited.pop_front();
        if (result_set !== want.result_set)
            report_mismatch("result_set", result_set, want.result_set);
        if (symbol_index !== want.symbol_index)
            report_mismatch("symbol_index", SET_W'(symbol_index), SET_W'(want.symbol_index));
        if (last !== want.last)
            report_mismatch("last", SET_W'(last), SET_W'(want.last));
    endtask

    function int pending();
        return awaited.size();
    endfunction
endclass

module nfa_subset_step_test;

    // indexes past the register list, writes there must be dropped
    localparam logic [INDEX_W-1:0] UNUSED_INDEX_LO = 3'd6;
    localparam logic [INDEX_W-1:0] UNUSED_INDEX_HI = 3'd7;

    localparam int QUIET_LIMIT   = 1000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 6;     // extra wait after the last expected result
    localparam int HOLD_CYCLES   = 60;    // long receiver hold-off to back the block up
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 40;

    logic                clk;
    logic                rst_n;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                kind = 1'b0;
    logic [SET_W-1:0]    state_set = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SET_W-1:0]    result_set;
    logic [SYM_W-1:0]    symbol_index;
    logic                last;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  cfg_index = '0;
    logic [MATRIX_W-1:0] cfg_data = '0;

    closure_scoreboard sb = new();

    // calm: no idling on either side; hold_left: receiver hold-off still to run
    bit calm = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int reg_writes = 0;
    int table_settings = 0;

    nfa_subset_step dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .state_set    (state_set),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_set   (result_set),
        .symbol_index (symbol_index),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // monitors: every accepted set goes to the scoreboard, every accepted result is checked
    // both sample the values that stood before the edge, all drives are nonblocking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_set(kind_t'(kind), state_set);
            if (out_valid && !out_stall)
                sb.check_result(result_set, symbol_index, last);
        end
    end

    // receiver: random stall, or a long hold-off counted down here
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < 32);
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: %0d cycles with no handshake, %0d results outstanding",
                         quiet_cycles, sb.pending());
                $display("nfa_subset_step regression: fail");
                $finish;
            end
        end
    end

    // offer one set, with a random idle gap in front unless calm
    task send_set(kind_t k, logic [SET_W-1:0] s);
        if (!calm)
        begin
            while ($urandom_range(99) < 32)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        kind <= k;
        state_set <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and wait until every expected result has come out
    task drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task cfg_write(logic [INDEX_W-1:0] index, logic [MATRIX_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(index, data);
        reg_writes++;
    endtask

    // load all five move tables and the symbol count; upper data bits of the count are junk
    task program_tables(move_tables_t tables, logic [CNT_W-1:0] count, bit poke_unused);
        logic [MATRIX_W-1:0] junk;
        junk = {$urandom, $urandom};
        cfg_write(REG_EPS_MOVES, tables[0]);
        cfg_write(REG_SYM0_MOVES, tables[1]);
        cfg_write(REG_SYM1_MOVES, tables[2]);
        cfg_write(REG_SYM2_MOVES, tables[3]);
        cfg_write(REG_SYM3_MOVES, tables[4]);
        if (poke_unused)
        begin
            cfg_write(UNUSED_INDEX_LO, ~junk);
            cfg_write(UNUSED_INDEX_HI, junk);
        end
        cfg_write(REG_SYMBOL_COUNT, {junk[MATRIX_W-1:CNT_W], count});
        cfg_valid <= 1'b0;
        table_settings++;
    endtask

    initial
    begin
        move_tables_t     tables;
        logic [SET_W-1:0] s;
        kind_t            k;

        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tables: no epsilon moves, one symbol with no moves
        send_set(KIND_CLOSURE, 8'hff);
        send_set(KIND_SUCCESSOR, 8'hff);
        send_set(KIND_CLOSURE, 8'h00);
        drain();

        // epsilon ring through all eight states, so closure has to stop on the cycle
        tables = '{64'h0180_4020_1008_0402, 64'h8040_2010_0804_0201, '1, '0,
                   64'h8000_0000_0000_0000};
        program_tables(tables, 3'd4, 1'b1);
        send_set(KIND_CLOSURE, 8'h01);
        send_set(KIND_SUCCESSOR, 8'h00);
        send_set(KIND_SUCCESSOR, 8'h80);
        send_set(KIND_SUCCESSOR, 8'hff);
        send_set(KIND_CLOSURE, 8'h00);
        send_set(KIND_CLOSURE, 8'haa);
        send_set(KIND_SUCCESSOR, 8'h55);
        drain();

        // full symbol tables, no epsilon moves, count of zero acts as one symbol
        tables = '{'0, '1, '1, '1, '1};
        program_tables(tables, 3'd0, 1'b0);
        send_set(KIND_SUCCESSOR, 8'h01);
        send_set(KIND_SUCCESSOR, 8'h00);
        send_set(KIND_CLOSURE, 8'h5a);
        drain();

        // full epsilon table, count above the symbol limit saturates
        tables = '{'1, 64'h0101_0101_0101_0101, '0, 64'h0101_0101_0101_0101, '0};
        program_tables(tables, 3'd7, 1'b0);
        send_set(KIND_CLOSURE, 8'h10);
        send_set(KIND_SUCCESSOR, 8'h02);
        send_set(KIND_SUCCESSOR, 8'hff);
        drain();

        // short epsilon chain, count just past the limit
        tables = '{64'h0000_0000_0000_0402, 64'h0000_0000_0000_0004, '0, '0,
                   64'h0000_0000_0000_0001};
        program_tables(tables, 3'd5, 1'b1);
        send_set(KIND_CLOSURE, 8'h01);
        send_set(KIND_SUCCESSOR, 8'h01);
        drain();

        // random phases: every symbol count once, sparse tables mostly so closures stay varied
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int m = 0; m < 5; m++)
            begin
                case ($urandom_range(9))
                    0:       tables[m] = '0;
                    1:       tables[m] = '1;
                    2, 3:    tables[m] = {$urandom, $urandom};
                    default: tables[m] = {$urandom, $urandom} & {$urandom, $urandom}
                                         & {$urandom, $urandom};
                endcase
            end
            program_tables(tables, CNT_W'(phase), phase[0]);

            // one phase with no idling at all, one with a long receiver hold-off
            calm = (phase == 2);
            if (phase == 5)
                hold_left = HOLD_CYCLES;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                k = kind_t'($urandom_range(1));
                case ($urandom_range(7))
                    0:       s = 8'h00;
                    1:       s = 8'hff;
                    default: s = SET_W'($urandom);
                endcase
                send_set(k, s);
            end
            drain();
        end
        calm = 1'b0;

        if (sb.pending() != 0)
            sb.report_mismatch("results never seen, count", SET_W'(sb.pending()), '0);

        $display("covered %0d closure and %0d successor sets, %0d results checked",
                 sb.closure_sets, sb.successor_sets, sb.results_seen);
        $display("across %0d table settings with %0d register writes, %0d mismatches",
                 table_settings, reg_writes, sb.errors);
        if (sb.errors == 0)
            $display("nfa_subset_step regression: pass");
        else
            $display("nfa_subset_step regression: fail");
        $finish;
    end

endmodule
